// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked property, checked also during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: rtl/becf_pkg.sv
// Package: constants, ROM tables and stage types of the exp correction pipeline.
`default_nettype none
package becf_pkg;

    localparam int ROM_SLOTS = 32;
    localparam int SLOT_W    = 5;
    localparam int LANE_LAT  = 17;

    localparam logic [17:0] CORR_MAX = 18'd262143;
    localparam logic [17:0] CORR_ONE = 18'd65536;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_BIN  = 2'd1;
    localparam logic [1:0] MODE_GAP  = 2'd2;

    // 2^(2^-k), k = 1..12, in Q30
    localparam logic [30:0] POW2_FRAC [12] = '{
        31'd1518500250, 31'd1276901416, 31'd1170923762, 31'd1121280436,
        31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
        31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544
    };

    typedef struct packed {
        logic [30:0]        m;
        logic [11:0]        fr;
        logic [5:0]         uh;
        logic signed [31:0] t;
        logic               low;
        logic [16:0]        flat;
        logic [16:0]        off;
    } becf_exp_st_t;

    function automatic logic [13:0] edge_lo(input logic [SLOT_W-1:0] i);
        logic [13:0] v;
        case (i)
            5'd0:  v = 14'd82;
            5'd1:  v = 14'd1024;
            5'd2:  v = 14'd1885;
            5'd3:  v = 14'd3318;
            5'd4:  v = 14'd3728;
            5'd5:  v = 14'd4137;
            5'd6:  v = 14'd4752;
            5'd7:  v = 14'd6390;
            5'd8:  v = 14'd6771;
            5'd9:  v = 14'd7373;
            5'd10: v = 14'd8192;
            5'd11: v = 14'd9012;
            5'd12: v = 14'd9421;
            5'd13: v = 14'd9831;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    function automatic logic [13:0] edge_hi(input logic [SLOT_W-1:0] i);
        logic [13:0] v;
        case (i)
            5'd0:  v = 14'd1024;
            5'd1:  v = 14'd1721;
            5'd2:  v = 14'd3154;
            5'd3:  v = 14'd3728;
            5'd4:  v = 14'd4137;
            5'd5:  v = 14'd4629;
            5'd6:  v = 14'd5899;
            5'd7:  v = 14'd6771;
            5'd8:  v = 14'd7373;
            5'd9:  v = 14'd8192;
            5'd10: v = 14'd9012;
            5'd11: v = 14'd9421;
            5'd12: v = 14'd9831;
            5'd13: v = 14'd10240;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] flat_q16(input logic [SLOT_W-1:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd66133;
            5'd1:  v = 17'd66259;
            5'd2:  v = 17'd66031;
            5'd3:  v = 17'd66031;
            5'd4:  v = 17'd66031;
            5'd5:  v = 17'd66031;
            5'd6:  v = 17'd66031;
            5'd7:  v = 17'd63816;
            5'd8:  v = 17'd64217;
            5'd9:  v = 17'd64301;
            5'd10: v = 17'd64292;
            5'd11: v = 17'd64293;
            5'd12: v = 17'd64201;
            5'd13: v = 17'd64201;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] off_q16(input logic [SLOT_W-1:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd64728;
            5'd1:  v = 17'd65315;
            5'd2:  v = 17'd65043;
            5'd3:  v = 17'd64873;
            5'd4:  v = 17'd64237;
            5'd5:  v = 17'd66088;
            5'd6:  v = 17'd64914;
            5'd7:  v = 17'd62970;
            5'd8:  v = 17'd62926;
            5'd9:  v = 17'd62463;
            5'd10: v = 17'd62210;
            5'd11: v = 17'd61409;
            5'd12: v = 17'd63513;
            5'd13: v = 17'd58174;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] knee_q12(input logic [SLOT_W-1:0] i);
        logic [16:0] v;
        case (i)
            5'd0:  v = 17'd72622;
            5'd1:  v = 17'd48041;
            5'd2:  v = 17'd55711;
            5'd3:  v = 17'd54762;
            5'd4:  v = 17'd45743;
            5'd5:  v = 17'd3734;
            5'd6:  v = 17'd9402;
            5'd7:  v = 17'd11767;
            5'd8:  v = 17'd11084;
            5'd9:  v = 17'd11630;
            5'd10: v = 17'd12605;
            5'd11: v = 17'd14080;
            5'd12: v = 17'd8916;
            5'd13: v = 17'd25808;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [24:0] slope_q16(input logic [SLOT_W-1:0] i);
        logic [24:0] v;
        case (i)
            5'd0:  v = 25'd46200;
            5'd1:  v = 25'd66144;
            5'd2:  v = 25'd59839;
            5'd3:  v = 25'd71178;
            5'd4:  v = 25'd69608;
            5'd5:  v = 25'd25291766;
            5'd6:  v = 25'd45750;
            5'd7:  v = 25'd33832;
            5'd8:  v = 25'd35684;
            5'd9:  v = 25'd27417;
            5'd10: v = 25'd30626;
            5'd11: v = 25'd44404;
            5'd12: v = 25'd44284;
            5'd13: v = 25'd65006;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [28:0] gain_q32(input logic [SLOT_W-1:0] i);
        logic signed [28:0] v;
        case (i)
            5'd0:  v = -29'sd17566;
            5'd1:  v = -29'sd18888;
            5'd2:  v = -29'sd15390;
            5'd3:  v = -29'sd4829;
            5'd4:  v = -29'sd46878;
            5'd5:  v = -29'sd31668443;
            5'd6:  v = -29'sd34925185;
            5'd7:  v = -29'sd60599068;
            5'd8:  v = -29'sd85875122;
            5'd9:  v = -29'sd148601703;
            5'd10: v = -29'sd131123647;
            5'd11: v = -29'sd82662869;
            5'd12: v = -29'sd87879068;
            5'd13: v = -29'sd10109375;
            default: v = 29'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/becf_lane.sv
// One bin-curve evaluation lane: ROM lookup, exp2 product chain, Q48 result.
`default_nettype none
module becf_lane (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [becf_pkg::SLOT_W-1:0]   slot,
    input  wire logic [14:0]                   ratio,
    output logic signed [63:0]                 f_q48
);
    import becf_pkg::*;

    // stage 1: ROM read and the two products
    logic signed [43:0] p_reg;
    logic signed [44:0] gr_reg;
    logic               low_reg;
    logic [16:0]        flat_reg;
    logic [16:0]        off_reg;
    logic signed [17:0] diff;

    assign diff = $signed({1'b0, knee_q12(slot)}) - $signed({3'b000, ratio});

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= diff * $signed({1'b0, slope_q16(slot)});
            gr_reg   <= gain_q32(slot) * $signed({1'b0, ratio});
            low_reg  <= (ratio < 15'd4096);
            flat_reg <= flat_q16(slot);
            off_reg  <= off_q16(slot);
        end
    end

    // stage 2: saturate log2 exponent, truncate gain term
    becf_exp_st_t       st_reg [13];
    logic signed [27:0] y;
    logic signed [27:0] ysat;
    logic [17:0]        u;
    logic signed [44:0] gr_adj;
    becf_exp_st_t       st0_next;

    always_comb begin
        y = p_reg[43:16];
        if (y < -28'sd131072) begin
            ysat = -28'sd131072;
        end else if (y > 28'sd65535) begin
            ysat = 28'sd65535;
        end else begin
            ysat = y;
        end
        u = 18'(ysat + 28'sd131072);
        // divide toward zero
        gr_adj = gr_reg[44] ? (gr_reg + 45'sd4095) : gr_reg;
        st0_next.m    = 31'd1073741824;
        st0_next.fr   = u[11:0];
        st0_next.uh   = u[17:12];
        st0_next.t    = 32'(gr_adj >>> 12);
        st0_next.low  = low_reg;
        st0_next.flat = flat_reg;
        st0_next.off  = off_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st0_next;
        end
    end

    // stages 3..14: one fraction bit per stage
    for (genvar k = 0; k < 12; k++) begin : g_exp
        logic [61:0]  prod;
        logic [62:0]  rnd;
        becf_exp_st_t nxt;
        always_comb begin
            prod = 62'(st_reg[k].m) * 62'(POW2_FRAC[k]);
            rnd  = {1'b0, prod} + 63'd536870912;
            nxt  = st_reg[k];
            if (st_reg[k].fr[11-k]) begin
                nxt.m = rnd[60:30];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= nxt;
            end
        end
    end

    // stage 15: scale to Q16 and form 1 - e
    logic signed [33:0] g_reg;
    logic signed [31:0] t15_reg;
    logic               low15_reg;
    logic [16:0]        flat15_reg;
    logic [16:0]        off15_reg;
    logic [5:0]         sh;
    logic [47:0]        sh_in;
    logic [47:0]        sh_out;
    logic [32:0]        e;

    always_comb begin
        sh     = 6'd46 - st_reg[12].uh;
        sh_in  = {16'd0, st_reg[12].m, 1'b0} + (48'd1 << sh);
        sh_out = sh_in >> (sh + 6'd1);
        if (st_reg[12].uh == 6'd47) begin
            e = {1'b0, st_reg[12].m, 1'b0};
        end else begin
            e = sh_out[32:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg      <= 34'sd65536 - $signed({1'b0, e});
            t15_reg    <= st_reg[12].t;
            low15_reg  <= st_reg[12].low;
            flat15_reg <= st_reg[12].flat;
            off15_reg  <= st_reg[12].off;
        end
    end

    // stage 16: split t*g into two partial products
    logic signed [49:0] pl_reg;
    logic signed [48:0] ph_reg;
    logic               low16_reg;
    logic [16:0]        flat16_reg;
    logic [16:0]        off16_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg     <= t15_reg * $signed({1'b0, g_reg[16:0]});
            ph_reg     <= t15_reg * $signed(g_reg[33:17]);
            low16_reg  <= low15_reg;
            flat16_reg <= flat15_reg;
            off16_reg  <= off15_reg;
        end
    end

    // stage 17: assemble Q48 value
    logic signed [63:0] f_reg;
    logic signed [63:0] f_next;

    always_comb begin
        if (low16_reg) begin
            f_next = $signed({15'd0, flat16_reg, 32'd0});
        end else begin
            f_next = $signed({15'd0, off16_reg, 32'd0})
                   + (64'(ph_reg) <<< 17) + 64'(pl_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg <= f_next;
        end
    end

    assign f_q48 = f_reg;

endmodule
`default_nettype wire

// File: rtl/binned_exp_correction_factor.sv
// Top level: eta bin search, two evaluation lanes, gap averaging and output rounding.
//
//  port group | dir | fields (lsb first)                  | width
//  s_*        | in  | eta_pos[15:0], shape_ratio[31:16]   | 32
//  m_*        | out | corr_factor[17:0]                   | 24
//
// One item per cycle while m_tready does not stall the output; the pipeline is bin search,
// 17 lane stages set by the 12-step exp2 multiply chain, gap sum and rounding.
// aresetn clears the valid bits only; data registers are not reset.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
`default_nettype none
module binned_exp_correction_factor #(
    parameter int NUM_BINS = 14
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // eta_pos[15:0], shape_ratio[31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // corr_factor[17:0], zeros above
);
    import becf_pkg::*;

    localparam int NB = (NUM_BINS > ROM_SLOTS) ? ROM_SLOTS : NUM_BINS;

    logic en;
    logic out_vld_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage 1: clamp and bin search
    logic [16:0]       a_abs;
    logic [16:0]       a_clip;
    logic [15:0]       r_raw;
    logic [14:0]       r_clip;
    logic              bin_hit;
    logic              gap_hit;
    logic [SLOT_W-1:0] bin_idx;
    logic [SLOT_W-1:0] gap_idx;
    logic [SLOT_W-1:0] idx_a;
    logic [1:0]        mode;

    always_comb begin
        a_abs = s_tdata[15] ? (17'h10000 - {1'b0, s_tdata[15:0]}) : {1'b0, s_tdata[15:0]};
        if (a_abs < 17'd82) begin
            a_clip = 17'd82;
        end else if (a_abs >= 17'd10240) begin
            a_clip = 17'd10199;
        end else begin
            a_clip = a_abs;
        end
        r_raw = s_tdata[31:16];
        if (r_raw < 16'd3277) begin
            r_clip = 15'd3277;
        end else if (r_raw > 16'd20480) begin
            r_clip = 15'd20480;
        end else begin
            r_clip = r_raw[14:0];
        end
        bin_hit = 1'b0;
        gap_hit = 1'b0;
        bin_idx = '0;
        gap_idx = '0;
        // last match wins
        for (int i = 0; i < NB; i++) begin
            if ({3'b000, edge_lo(SLOT_W'(i))} <= a_clip
                && a_clip < {3'b000, edge_hi(SLOT_W'(i))}) begin
                bin_hit = 1'b1;
                bin_idx = SLOT_W'(i);
            end
        end
        for (int i = 0; i + 1 < NB; i++) begin
            if ({3'b000, edge_hi(SLOT_W'(i))} <= a_clip
                && a_clip < {3'b000, edge_lo(SLOT_W'(i + 1))}) begin
                gap_hit = 1'b1;
                gap_idx = SLOT_W'(i);
            end
        end
        if (bin_hit) begin
            mode  = MODE_BIN;
            idx_a = bin_idx;
        end else if (gap_hit) begin
            mode  = MODE_GAP;
            idx_a = gap_idx;
        end else begin
            mode  = MODE_NONE;
            idx_a = '0;
        end
    end

    logic              v1_reg;
    logic [1:0]        mode1_reg;
    logic [SLOT_W-1:0] idx_a_reg;
    logic [SLOT_W-1:0] idx_b_reg;
    logic [14:0]       r1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= mode;
            idx_a_reg <= idx_a;
            idx_b_reg <= idx_a + SLOT_W'(1);
            r1_reg    <= r_clip;
        end
    end

    // two lanes
    logic signed [63:0] fa;
    logic signed [63:0] fb;

    becf_lane u_lane_a (
        .aclk  (aclk),
        .en    (en),
        .slot  (idx_a_reg),
        .ratio (r1_reg),
        .f_q48 (fa)
    );

    becf_lane u_lane_b (
        .aclk  (aclk),
        .en    (en),
        .slot  (idx_b_reg),
        .ratio (r1_reg),
        .f_q48 (fb)
    );

    // valid and mode travel alongside the lanes
    logic [LANE_LAT-1:0] vld_pipe_reg;
    logic [1:0]          mode_pipe_reg [LANE_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_pipe_reg <= '0;
        end else if (en) begin
            vld_pipe_reg <= {vld_pipe_reg[LANE_LAT-2:0], v1_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_pipe_reg[0] <= mode1_reg;
            for (int k = 1; k < LANE_LAT; k++) begin
                mode_pipe_reg[k] <= mode_pipe_reg[k-1];
            end
        end
    end

    // sum stage: a bin counts twice so both cases round at 2^33
    logic               vs_reg;
    logic               none_reg;
    logic signed [64:0] sum_reg;
    logic signed [64:0] sum_next;

    always_comb begin
        case (mode_pipe_reg[LANE_LAT-1])
            MODE_BIN: sum_next = 65'(fa) <<< 1;
            MODE_GAP: sum_next = 65'(fa) + 65'(fb);
            default:  sum_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg <= 1'b0;
        end else if (en) begin
            vs_reg <= vld_pipe_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg  <= sum_next;
            none_reg <= (mode_pipe_reg[LANE_LAT-1] == MODE_NONE);
        end
    end

    // output stage: round half up, saturate
    logic [65:0] rnd;
    logic [32:0] q;
    logic [17:0] corr_next;
    logic [17:0] corr_reg;

    always_comb begin
        rnd = 66'(sum_reg) + (66'd1 << 32);
        q   = rnd[65:33];
        if (none_reg) begin
            corr_next = CORR_ONE;
        end else if (sum_reg <= 65'sd0) begin
            corr_next = '0;
        end else if (q > 33'(CORR_MAX)) begin
            corr_next = CORR_MAX;
        end else begin
            corr_next = q[17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vs_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            corr_reg <= corr_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, corr_reg};

endmodule
`default_nettype wire

// File: rtl/becf_checker.sv
// Port-level checker for the correction block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module becf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    `ASSERT_CLK(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `ASSERT_CLK(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_CLK(a_ready_follows, aclk, aresetn, s_tready == (!m_tvalid || m_tready))
    `ASSERT_CLK(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[23:18] == 6'd0)
endmodule

bind binned_exp_correction_factor becf_checker u_becf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
